// ===== sv/usbhps_pkg.sv =====
// Package for the USB 2.0 hub port status emulator.
// Holds event codes, status and change bit masks, feature numbers and speed codes.
// No dependencies.
package usbhps_pkg;

  typedef logic [3:0]  op_t;
  typedef logic [15:0] word_t;
  typedef logic [1:0]  speed_t;

  localparam op_t OP_ATTACH        = 4'd0;
  localparam op_t OP_DETACH        = 4'd1;
  localparam op_t OP_SET_PORT_FEAT = 4'd2;
  localparam op_t OP_CLR_PORT_FEAT = 4'd3;
  localparam op_t OP_GET_PORT_STAT = 4'd4;
  localparam op_t OP_GET_HUB_STAT  = 4'd5;
  localparam op_t OP_SET_HUB_FEAT  = 4'd6;
  localparam op_t OP_CLR_HUB_FEAT  = 4'd7;
  localparam op_t OP_INT_DONE      = 4'd8;

  localparam word_t ST_CONNECTION = 16'h0001;
  localparam word_t ST_ENABLE     = 16'h0002;
  localparam word_t ST_POWER      = 16'h0100;
  localparam word_t ST_LOW_SPEED  = 16'h0200;
  localparam word_t ST_HIGH_SPEED = 16'h0400;
  localparam word_t CH_CONNECTION = 16'h0001;
  localparam word_t CH_RESET      = 16'h0010;

  localparam word_t FEAT_PORT_RESET    = 16'd4;
  localparam word_t FEAT_PORT_POWER    = 16'd8;
  localparam word_t FEAT_C_CONNECTION  = 16'd16;
  localparam word_t FEAT_C_RESET       = 16'd20;
  localparam word_t FEAT_HUB_MAX       = 16'd1;

  localparam speed_t SPEED_FULL = 2'd0;
  localparam speed_t SPEED_HIGH = 2'd1;
  localparam speed_t SPEED_LOW  = 2'd2;

  localparam logic [1:0] OUTCOME_RESUBMIT = 2'd2;

  function automatic logic port_feature_known(input word_t f);
    port_feature_known = (f <= 16'd4) || (f == 16'd8) || (f == 16'd9) ||
                         ((f >= 16'd16) && (f <= 16'd22));
  endfunction

endpackage

// ===== sv/usb_hub_port_status_emulator.sv =====
// Top level of the USB 2.0 hub port status emulator.
// Keeps per-port status and change words and the report-pending flag.
// Depends on usbhps_pkg.
//
// Usage:
//   An item (op, port_number, feature_selector, transfer_outcome) is taken at a
//   rising edge with start high and busy low. busy is held low: one item may
//   enter in every cycle.
//   The item is captured in an input register; the following cycle evaluates it
//   against the port tables and loads the result register. done is loaded with
//   it and is high for one cycle together with accepted, status_word,
//   change_word, change_bitmap and send_interrupt.
//   Throughput is one item per cycle; the port tables sit in flip-flops, and
//   the one decode-and-update pass between input and result register sets it.
//   The receiver cannot hold results off; every result is shown exactly once.
//   cfg_we with cfg_data writes device_speed; write only while no item is in
//   flight.
//   Reset clears all port words and the pending flag and sets device_speed to
//   high speed.
module usb_hub_port_status_emulator #(
  parameter int NUM_PORTS = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  usbhps_pkg::op_t       op,
  input  logic [15:0]           port_number,
  input  logic [15:0]           feature_selector,
  input  logic [1:0]            transfer_outcome,
  input  logic                  cfg_we,
  input  usbhps_pkg::speed_t    cfg_data,
  output logic                  done,
  output logic                  accepted,
  output logic [15:0]           status_word,
  output logic [15:0]           change_word,
  output logic [7:0]            change_bitmap,
  output logic                  send_interrupt
);
  import usbhps_pkg::*;

  localparam int IDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

  speed_t      device_speed;
  logic        item_valid;
  op_t         op_q;
  logic [15:0] port_q;
  word_t       feat_q;
  logic [1:0]  outcome_q;
  word_t       port_status [NUM_PORTS];
  word_t       port_change [NUM_PORTS];
  word_t       port_status_next [NUM_PORTS];
  word_t       port_change_next [NUM_PORTS];
  logic        report_pending;
  logic        report_pending_next;

  logic             port_ok;
  logic [IDX_W-1:0] idx;
  word_t            st_sel;
  word_t            ch_sel;
  word_t            st_new;
  word_t            ch_new;
  logic             wr;
  logic             acc;
  logic             show;
  logic             chg_event;
  logic             int_done;
  logic             send;
  logic [7:0]       bitmap_next;
  logic [15:0]      port_m1;

  assign busy = 1'b0;

  assign port_ok = (port_q >= 16'd1) && (port_q <= 16'(NUM_PORTS));
  assign port_m1 = port_q - 16'd1;
  assign idx     = port_ok ? port_m1[IDX_W-1:0] : '0;
  assign st_sel  = port_status[idx];
  assign ch_sel  = port_change[idx];

  always_comb begin
    acc       = 1'b0;
    show      = 1'b0;
    wr        = 1'b0;
    chg_event = 1'b0;
    int_done  = 1'b0;
    st_new    = st_sel;
    ch_new    = ch_sel;
    unique case (op_q)
      OP_ATTACH: begin
        if (port_ok) begin
          st_new = st_sel | ST_CONNECTION | ST_ENABLE;
          if (device_speed == SPEED_HIGH) begin
            st_new = st_new | ST_HIGH_SPEED;
          end else if (device_speed == SPEED_LOW) begin
            st_new = st_new | ST_LOW_SPEED;
          end
          ch_new    = ch_sel | CH_CONNECTION;
          wr        = 1'b1;
          chg_event = 1'b1;
          acc       = 1'b1;
          show      = 1'b1;
        end
      end
      OP_DETACH: begin
        if (port_ok) begin
          st_new    = st_sel & ~(ST_CONNECTION | ST_ENABLE | ST_HIGH_SPEED | ST_LOW_SPEED);
          ch_new    = ch_sel | CH_CONNECTION;
          wr        = 1'b1;
          chg_event = 1'b1;
          acc       = 1'b1;
          show      = 1'b1;
        end
      end
      OP_SET_PORT_FEAT: begin
        if (port_ok && port_feature_known(feat_q)) begin
          if (feat_q == FEAT_PORT_RESET) begin
            ch_new    = ch_sel | CH_RESET;
            chg_event = 1'b1;
          end else if (feat_q == FEAT_PORT_POWER) begin
            st_new = st_sel | ST_POWER;
          end
          wr   = 1'b1;
          acc  = 1'b1;
          show = 1'b1;
        end
      end
      OP_CLR_PORT_FEAT: begin
        if (port_ok && port_feature_known(feat_q)) begin
          if (feat_q == FEAT_C_CONNECTION) begin
            ch_new = ch_sel & ~CH_CONNECTION;
          end else if (feat_q == FEAT_C_RESET) begin
            ch_new = ch_sel & ~CH_RESET;
          end
          wr   = 1'b1;
          acc  = 1'b1;
          show = 1'b1;
        end
      end
      OP_GET_PORT_STAT: begin
        if (port_ok) begin
          acc  = 1'b1;
          show = 1'b1;
        end
      end
      OP_GET_HUB_STAT: begin
        acc = 1'b1;
      end
      OP_SET_HUB_FEAT, OP_CLR_HUB_FEAT: begin
        acc = (feat_q <= FEAT_HUB_MAX);
      end
      OP_INT_DONE: begin
        acc      = 1'b1;
        int_done = 1'b1;
      end
      default: begin
        acc = 1'b0;
      end
    endcase
  end

  always_comb begin
    bitmap_next = '0;
    for (int i = 0; i < NUM_PORTS; i++) begin
      if (item_valid && wr && (idx == IDX_W'(i))) begin
        port_status_next[i] = st_new;
        port_change_next[i] = ch_new;
      end else begin
        port_status_next[i] = port_status[i];
        port_change_next[i] = port_change[i];
      end
      bitmap_next[3'(i + 1)] = (port_change_next[i] != '0);
    end
  end

  always_comb begin
    report_pending_next = report_pending;
    send                = 1'b0;
    if (item_valid && chg_event) begin
      if (bitmap_next != '0) begin
        send                = !report_pending;
        report_pending_next = 1'b1;
      end else begin
        report_pending_next = 1'b0;
      end
    end else if (item_valid && int_done) begin
      report_pending_next = (outcome_q >= OUTCOME_RESUBMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid     <= 1'b0;
      done           <= 1'b0;
      report_pending <= 1'b0;
      device_speed   <= SPEED_HIGH;
      for (int i = 0; i < NUM_PORTS; i++) begin
        port_status[i] <= '0;
        port_change[i] <= '0;
      end
    end else begin
      item_valid     <= start && !busy;
      done           <= item_valid;
      report_pending <= report_pending_next;
      if (cfg_we) begin
        device_speed <= cfg_data;
      end
      for (int i = 0; i < NUM_PORTS; i++) begin
        port_status[i] <= port_status_next[i];
        port_change[i] <= port_change_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    op_q           <= op;
    port_q         <= port_number;
    feat_q         <= feature_selector;
    outcome_q      <= transfer_outcome;
    accepted       <= acc;
    status_word    <= show ? st_new : '0;
    change_word    <= show ? ch_new : '0;
    change_bitmap  <= bitmap_next;
    send_interrupt <= item_valid && send;
  end

endmodule
